>>> rtl/akvt_pkg.sv
// shared types and constants for the array key-value table
// no dependencies; imported by akvt_ctrl, akvt_dpath and array_key_value_table

package akvt_pkg;

	localparam int unsigned KEY_W         = 32;
	localparam int unsigned VALUE_W       = 32;
	localparam int unsigned CMD_W         = 3;
	localparam int unsigned ENTRY_COUNT_W = 9;

	// request commands; codes five to seven are ignored
	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 3'd0,
		CMD_ACCESS = 3'd1,
		CMD_WRITE  = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	// request beat
	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic signed [KEY_W-1:0]   req_key;
		logic signed [VALUE_W-1:0] req_value;
	} req_t;

	// result beat
	typedef struct packed {
		logic signed [VALUE_W-1:0]  rd_value;
		logic                       hit;
		logic                       table_full;
		logic [ENTRY_COUNT_W-1:0]   entry_count;
	} rsp_t;

	// one table row
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} kv_entry_t;

	// source of the returned value
	typedef enum logic [1:0] {
		RV_ZERO,
		RV_STORED,
		RV_REQ
	} rv_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic    load;
		logic    rd_issue;
		logic    wr_upd;
		logic    wr_app;
		logic    shift_start;
		logic    shift_wr;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cnt_clr;
		logic    fin;
		logic    fin_hit;
		logic    fin_full;
		rv_sel_t fin_rv;
	} ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic             match;
		logic             drained;
		logic             room;
		logic [CMD_W-1:0] cmd;
	} sts_t;

endpackage

>>> rtl/akvt_ctrl.sv
// request sequencer for the key-value table: scan, update, shift and finish
// depends on akvt_pkg (ctl_t, sts_t, cmd_t)

module akvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  akvt_pkg::sts_t sts,
	output akvt_pkg::ctl_t ctl
);
	import akvt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign busy = (state_q != S_IDLE);

	// command decode per state
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				unique case (sts.cmd)
					CMD_LOOKUP: begin
						priority if (sts.match) begin
							ctl.fin     = 1'b1;
							ctl.fin_hit = 1'b1;
							ctl.fin_rv  = RV_STORED;
							state_d     = S_IDLE;
						end else if (sts.drained) begin
							ctl.fin = 1'b1;
							state_d = S_IDLE;
						end else begin
							ctl.rd_issue = 1'b1;
						end
					end
					CMD_ACCESS, CMD_WRITE: begin
						priority if (sts.match) begin
							ctl.fin     = 1'b1;
							ctl.fin_hit = 1'b1;
							if (sts.cmd == CMD_WRITE) begin
								ctl.wr_upd = 1'b1;
								ctl.fin_rv = RV_REQ;
							end else begin
								ctl.fin_rv = RV_STORED;
							end
							state_d = S_IDLE;
						end else if (sts.drained) begin
							ctl.fin = 1'b1;
							if (sts.room) begin
								ctl.wr_app  = 1'b1;
								ctl.cnt_inc = 1'b1;
								ctl.fin_rv  = (sts.cmd == CMD_WRITE) ? RV_REQ : RV_ZERO;
							end else begin
								ctl.fin_full = 1'b1;
							end
							state_d = S_IDLE;
						end else begin
							ctl.rd_issue = 1'b1;
						end
					end
					CMD_DELETE: begin
						priority if (sts.match) begin
							ctl.shift_start = 1'b1;
							state_d         = S_SHIFT;
						end else if (sts.drained) begin
							ctl.fin = 1'b1;
							state_d = S_IDLE;
						end else begin
							ctl.rd_issue = 1'b1;
						end
					end
					CMD_CLEAR: begin
						ctl.cnt_clr = 1'b1;
						ctl.fin     = 1'b1;
						state_d     = S_IDLE;
					end
					default: begin
						ctl.fin = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_SHIFT: begin
				if (sts.drained) begin
					ctl.cnt_dec = 1'b1;
					ctl.fin     = 1'b1;
					ctl.fin_hit = 1'b1;
					state_d     = S_IDLE;
				end else begin
					ctl.rd_issue = 1'b1;
					ctl.shift_wr = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/akvt_dpath.sv
// datapath of the key-value table: row memory, scan pointer, live count, result register
// depends on akvt_pkg (req_t, rsp_t, kv_entry_t, ctl_t, sts_t)

module akvt_dpath #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  akvt_pkg::req_t req,
	input  akvt_pkg::ctl_t ctl,
	output akvt_pkg::sts_t sts,
	output logic           done,
	output akvt_pkg::rsp_t rsp
);
	import akvt_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = $clog2(CAPACITY);

	kv_entry_t kv_mem [CAPACITY];

	req_t      req_q;
	rsp_t      rsp_q;
	logic      done_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic [CW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	kv_entry_t     mem_rd_s1;

	logic          rd_fire;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	kv_entry_t     wr_data;
	logic [VALUE_W-1:0] app_value;
	logic [VALUE_W-1:0] fin_value;

	// scan reads stop at the live count
	assign rd_fire = ctl.rd_issue && (idx_q < count_q);

	// status toward the controller
	assign sts.match   = rd_vld_s1 && (mem_rd_s1.key == req_q.req_key);
	assign sts.drained = !rd_vld_s1 && (idx_q >= count_q);
	assign sts.room    = (count_q < CW'(CAPACITY));
	assign sts.cmd     = req_q.cmd;

	// row write port: update in place, append, or shift down one place
	assign app_value = (req_q.cmd == CMD_WRITE) ? req_q.req_value : '0;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = rd_idx_s1;
		wr_data = mem_rd_s1;
		priority if (ctl.wr_upd) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1;
			wr_data = '{key: req_q.req_key, value: req_q.req_value};
		end else if (ctl.wr_app) begin
			wr_en   = 1'b1;
			wr_addr = count_q[IW-1:0];
			wr_data = '{key: req_q.req_key, value: app_value};
		end else if (ctl.shift_wr && rd_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1 - IW'(1);
			wr_data = mem_rd_s1;
		end
	end

	// row memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			kv_mem[wr_addr] <= wr_data;
		end
		if (rd_fire) begin
			mem_rd_s1 <= kv_mem[idx_q[IW-1:0]];
			rd_idx_s1 <= idx_q[IW-1:0];
		end
	end

	// live count after this request
	always_comb begin
		priority if (ctl.cnt_clr) begin
			count_next = '0;
		end else if (ctl.cnt_inc) begin
			count_next = count_q + CW'(1);
		end else if (ctl.cnt_dec) begin
			count_next = count_q - CW'(1);
		end else begin
			count_next = count_q;
		end
	end

	// returned value
	always_comb begin
		unique case (ctl.fin_rv)
			RV_STORED: fin_value = mem_rd_s1.value;
			RV_REQ:    fin_value = req_q.req_value;
			default:   fin_value = '0;
		endcase
	end

	// scan pointer, read valid, count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			if (ctl.load) begin
				idx_q <= '0;
			end else if (ctl.shift_start) begin
				idx_q <= CW'(rd_idx_s1) + CW'(1);
			end else if (rd_fire) begin
				idx_q <= idx_q + CW'(1);
			end
			rd_vld_s1 <= rd_fire && !ctl.load && !ctl.shift_start;
			count_q   <= count_next;
			done_q    <= ctl.fin;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (ctl.fin) begin
			rsp_q.rd_value    <= fin_value;
			rsp_q.hit         <= ctl.fin_hit;
			rsp_q.table_full  <= ctl.fin_full;
			rsp_q.entry_count <= ENTRY_COUNT_W'(count_next);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("live count above capacity");

	// a refused insert only happens on a full table
	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fin && ctl.fin_full) |-> (count_q == CW'(CAPACITY)))
		else $error("insert refused with free rows");

	// an append never lands on a full table
	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_app |-> (count_q < CW'(CAPACITY)))
		else $error("append beyond capacity");

endmodule

>>> rtl/array_key_value_table.sv
// Packed key-value table searched one row per cycle. A request is taken when start is
// high and busy is low; busy stays high until the cycle of the done strobe, in which
// the next request may already be taken. The result is on rsp for exactly that one
// cycle and must be captured there. Lookup, access and write scan the live rows in
// order from row 0 and stop at the matching key, or after the last live row on a
// miss. Delete scans the same way; on a hit the rows behind the key move down one
// place, one per cycle. Clear and unused codes finish without a scan. The search
// rate is set by the single read port of the row memory.
// depends on akvt_pkg, akvt_ctrl, akvt_dpath

module array_key_value_table #(
	parameter int unsigned CAPACITY = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  akvt_pkg::req_t req,
	output logic           done,
	output akvt_pkg::rsp_t rsp
);
	import akvt_pkg::*;

	ctl_t ctl;
	sts_t sts;

	akvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.ctl    (ctl)
	);

	akvt_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

	// an accepted request always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// result beat only comes once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// a refused insert never reports a hit or a value
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.table_full) |-> (!rsp.hit && (rsp.rd_value == '0)))
		else $error("refused insert with hit or value");

endmodule
